@@ hw/rtl/md5_pkg.sv @@
// shared types, constants and round functions for the md5 digest block
package md5_pkg;

   // input transfer payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } md5_req_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] digest_byte;
      logic       digest_last;
   } md5_rsp_type;

   // front to block queue: word write and block push
   typedef struct packed {
      logic        we;
      logic [3:0]  widx;
      logic [31:0] wdata;
      logic        push;
      logic        push_last;
   } md5_qwr_type;

   // back to block queue: word read and block pop
   typedef struct packed {
      logic [3:0] ridx;
      logic       pop;
   } md5_qrd_type;

   // block queue status
   typedef struct packed {
      logic full;
      logic avail;
      logic last;
   } md5_qstat_type;

   // chaining word start values
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // message word used by round i
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] lo;
      logic [3:0] res;
      lo = i[3:0];
      case (i[5:4])
         2'd0: res = lo;
         2'd1: res = 4'((lo << 2) + lo + 4'd1);
         2'd2: res = 4'((lo << 1) + lo + 4'd5);
         2'd3: res = 4'((lo << 3) - lo);
         default: res = lo;
      endcase
      return res;
   endfunction

   // rotate amount of round i
   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r;
      case ({i[5:4], i[1:0]})
         4'd0:  r = 5'd7;
         4'd1:  r = 5'd12;
         4'd2:  r = 5'd17;
         4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;
         4'd5:  r = 5'd9;
         4'd6:  r = 5'd14;
         4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;
         4'd9:  r = 5'd11;
         4'd10: r = 5'd16;
         4'd11: r = 5'd23;
         4'd12: r = 5'd6;
         4'd13: r = 5'd10;
         4'd14: r = 5'd15;
         4'd15: r = 5'd21;
         default: r = 5'd7;
      endcase
      return r;
   endfunction

   // left rotate of a 32-bit word
   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
      logic [63:0] dbl;
      dbl = {v, v} << r;
      return dbl[63:32];
   endfunction

   // sine constant of round i
   function automatic logic [31:0] sine_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         6'd63: k = 32'heb86d391;
         default: k = 32'hd76aa478;
      endcase
      return k;
   endfunction

endpackage

@@ hw/rtl/md5_block_queue.sv @@
// two-slot block store between the byte front end and the compression core
module md5_block_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::md5_qwr_type  q_wr,
   input  md5_pkg::md5_qrd_type  q_rd,
   output md5_pkg::md5_qstat_type q_stat,
   output logic [31:0]           rd_data
);
   import md5_pkg::*;

   logic [31:0] mem [32];
   logic [31:0] rd_data_ff;
   logic [1:0]  count_ff, count_in;
   logic        wr_slot_ff, wr_slot_in;
   logic        rd_slot_ff, rd_slot_in;
   logic [1:0]  last_ff, last_in;

   // slot bookkeeping
   always_comb begin
      count_in   = count_ff + {1'b0, q_wr.push} - {1'b0, q_rd.pop};
      wr_slot_in = wr_slot_ff ^ q_wr.push;
      rd_slot_in = rd_slot_ff ^ q_rd.pop;
      last_in    = last_ff;
      if (q_wr.push) begin
         last_in[wr_slot_ff] = q_wr.push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wr_slot_ff <= 1'b0;
         rd_slot_ff <= 1'b0;
         last_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         last_ff    <= last_in;
      end
   end

   // word store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (q_wr.we) begin
         mem[{wr_slot_ff, q_wr.widx}] <= q_wr.wdata;
      end
      rd_data_ff <= mem[{rd_slot_ff, q_rd.ridx}];
   end

   assign rd_data      = rd_data_ff;
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.avail = (count_ff != 2'd0);
   assign q_stat.last  = last_ff[rd_slot_ff];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("block queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (q_wr.push || q_wr.we) |-> (count_ff != 2'd2))
      else $error("block written while queue full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_rd.pop |-> (count_ff != 2'd0))
      else $error("block popped from empty queue");

endmodule

@@ hw/rtl/md5_front.sv @@
// byte front end: gathers message bytes into words, pads and appends the length
module md5_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  md5_pkg::md5_req_type   req_data,
   input  md5_pkg::md5_qstat_type q_stat,
   output md5_pkg::md5_qwr_type   q_wr
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      F_MSG = 3'b001,
      F_PAD = 3'b010,
      F_LEN = 3'b100
   } front_state_type;

   localparam logic [5:0] LAST_PAD_POS = 6'd55;
   localparam logic [5:0] LAST_POS     = 6'd63;

   front_state_type state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [60:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic [23:0] acc_ff, acc_in;
   logic        first_ff, first_in;
   logic        wr_go;
   logic [7:0]  wr_byte;
   logic [60:0] count_next;

   assign count_next = count_ff + 61'(req_data.byte_valid);

   // byte source selection and sequencing
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      req_ready = 1'b0;
      wr_go     = 1'b0;
      wr_byte   = req_data.data_byte;
      case (state_ff)
         F_MSG: begin
            req_ready = !q_stat.full;
            if (req_valid && !q_stat.full) begin
               wr_go    = req_data.byte_valid;
               count_in = count_next;
               if (req_data.end_of_message) begin
                  len_in   = {count_next, 3'b000};
                  first_in = 1'b1;
                  state_in = F_PAD;
               end
            end
         end
         F_PAD: begin
            wr_byte = first_ff ? PAD_BYTE : 8'h00;
            if (!q_stat.full) begin
               wr_go    = 1'b1;
               first_in = 1'b0;
               if (pos_ff == LAST_PAD_POS) begin
                  state_in = F_LEN;
               end
            end
         end
         F_LEN: begin
            wr_byte = len_ff[8*pos_ff[2:0] +: 8];
            if (!q_stat.full) begin
               wr_go = 1'b1;
               if (pos_ff == LAST_POS) begin
                  count_in = '0;
                  state_in = F_MSG;
               end
            end
         end
         default: state_in = F_MSG;
      endcase
   end

   // little-endian word assembly and block completion
   always_comb begin
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      q_wr.we        = 1'b0;
      q_wr.widx      = pos_ff[5:2];
      q_wr.wdata     = {wr_byte, acc_ff};
      q_wr.push      = 1'b0;
      q_wr.push_last = (state_ff == F_LEN);
      if (wr_go) begin
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'd3) begin
            q_wr.we = 1'b1;
         end else begin
            acc_in[8*pos_ff[1:0] +: 8] = wr_byte;
         end
         q_wr.push = (pos_ff == LAST_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_MSG;
         pos_ff   <= '0;
         count_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      acc_ff <= acc_in;
   end

endmodule

@@ hw/rtl/md5_core.sv @@
// compression core: one round a cycle, chaining update and digest output
module md5_core (
   input  logic                   clock,
   input  logic                   reset,
   input  md5_pkg::md5_qstat_type q_stat,
   input  logic [31:0]            rd_data,
   output md5_pkg::md5_qrd_type   q_rd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output md5_pkg::md5_rsp_type   rsp_data
);
   import md5_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_ROUND = 4'b0010,
      B_ADD   = 4'b0100,
      B_OUT   = 4'b1000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [3:0]  ocnt_ff, ocnt_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic        rsp_valid_ff, rsp_valid_in;
   md5_rsp_type rsp_data_ff, rsp_data_in;
   logic [31:0] f_val, t_val, word_out;
   logic        load;

   // round function and sum
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
      t_val = f_val + a_ff + sine_k(rnd_ff) + rd_data;
   end

   assign word_out = chain_ff[ocnt_ff[3:2]];
   assign load     = !rsp_valid_ff || rsp_ready;

   // sequencing of block rounds and digest output
   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      ocnt_in      = ocnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_rd.pop     = 1'b0;
      q_rd.ridx    = (state_ff == B_IDLE) ? msg_index(6'd0) : msg_index(rnd_ff + 6'd1);
      case (state_ff)
         B_IDLE: begin
            if (q_stat.avail) begin
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
               rnd_in   = '0;
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            a_in   = d_ff;
            d_in   = c_ff;
            c_in   = b_ff;
            b_in   = b_ff + rotl32(t_val, rot_amount(rnd_ff));
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = B_ADD;
            end
         end
         B_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            q_rd.pop    = 1'b1;
            ocnt_in     = '0;
            state_in    = q_stat.last ? B_OUT : B_IDLE;
         end
         B_OUT: begin
            if (load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_byte = word_out[8*ocnt_ff[1:0] +: 8];
               rsp_data_in.digest_last = (ocnt_ff == 4'd15);
               ocnt_in                 = ocnt_ff + 4'd1;
               if (ocnt_ff == 4'd15) begin
                  chain_in[0] = INIT_A;
                  chain_in[1] = INIT_B;
                  chain_in[2] = INIT_C;
                  chain_in[3] = INIT_D;
                  state_in    = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rnd_ff       <= '0;
         ocnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff[0]  <= INIT_A;
         chain_ff[1]  <= INIT_B;
         chain_ff[2]  <= INIT_C;
         chain_ff[3]  <= INIT_D;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         ocnt_ff      <= ocnt_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // working variables and output payload
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// top level of the streaming md5 digest block
// Streaming MD5 hasher. One message byte is taken per transfer; a transfer with
// end_of_message set (with or without a byte) closes the message, and the 16
// digest bytes follow on the rsp channel, lowest byte of the first chaining word
// first, digest_last on the sixteenth. The front end takes one transfer per cycle
// into a two-block store while that is not full and no message is being padded,
// so it can fill one block while the core compresses the other. The core takes
// each 64-byte block as a read lead-in, 64 rounds and a chaining add. Closing
// a message makes the front end write 9 to 72 padding and length bytes (up to
// two blocks); the next message may be fed in while the digest drains.
module md5_message_digest (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  md5_pkg::md5_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output md5_pkg::md5_rsp_type rsp_data
);
   import md5_pkg::*;

   md5_qwr_type   q_wr;
   md5_qrd_type   q_rd;
   md5_qstat_type q_stat;
   logic [31:0]   rd_data;

   // byte gathering and padding
   md5_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_wr      (q_wr)
   );

   // block store between front and core
   md5_block_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_rd    (q_rd),
      .q_stat  (q_stat),
      .rd_data (rd_data)
   );

   // compression and digest output
   md5_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .rd_data   (rd_data),
      .q_rd      (q_rd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
